### hw/rtl/mmfn_pkg.sv
// shared types and constants for the min-max feature normalizer
// no dependencies; used by mmfn_divider and min_max_feature_normalizer_core

package mmfn_pkg;

    localparam int MMFN_COLUMNS = 64;

    localparam int FUNC_W    = 2;
    localparam int COLUMN_W  = 6;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 1;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GATHER    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NORMALIZE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam logic signed [DATA_W-1:0] RANGE_LOW_RESET  = 32'sd0;
    localparam logic signed [DATA_W-1:0] RANGE_HIGH_RESET = 32'sd65536;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic [COLUMN_W-1:0]        column;
        logic signed [DATA_W-1:0]   sample;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   scaled;
        logic [COLUMN_W-1:0]        column_echo;
    } out_item_t;

endpackage

### hw/rtl/mmfn_divider.sv
// radix-2 restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle
// depends on mmfn_pkg for widths

module mmfn_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mmfn_pkg::PROD_W-1:0]   dividend,
    input  logic [mmfn_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [mmfn_pkg::PROD_W-1:0]   quotient
);
    import mmfn_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

    logic [PROD_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // remainder stays below the divisor, so it fits in DATA_W bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/min_max_feature_normalizer_core.sv
// top level of the min-max feature normalizer: column extreme stores,
// control sequencer and result formatting; depends on mmfn_pkg and mmfn_divider
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | in_valid / in_ready       | in_data  (func, column, sample)
//  out     | output    | out_valid / out_ready     | out_data (scaled, column_echo)
//  cfg     | input     | cfg_we, no wait           | cfg_index, cfg_data
//
// one request at a time: gather passes through a read state, normalize runs
// through the 64-step bit-serial divider, and clear is a write sweep through
// both column stores, one entry per cycle.
// after reset the same sweep runs before in_ready rises.
// a finished result sits in the output register; the next request is taken
// while it waits, and only a second result stalls behind it.

module min_max_feature_normalizer_core #(
    parameter int COLUMNS = mmfn_pkg::MMFN_COLUMNS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mmfn_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mmfn_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [mmfn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmfn_pkg::DATA_W-1:0]       cfg_data
);
    import mmfn_pkg::*;

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(COLUMNS - 1);
    localparam int SUM_W = DATA_W + 4;
    localparam int MAG_W = DATA_W + 3;
    localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(1) << (DATA_W + 2);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_READ  = 7'b000_0100,
        S_MUL   = 7'b000_1000,
        S_LOAD  = 7'b001_0000,
        S_DIV   = 7'b010_0000,
        S_DONE  = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic signed [DATA_W-1:0] range_low_reg, range_high_reg;

    // request holding registers
    logic [FUNC_W-1:0]        func_reg;
    logic [COLUMN_W-1:0]      col_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic                     col_ok_reg;

    // column stores
    logic signed [DATA_W-1:0] min_mem [COLUMNS];
    logic signed [DATA_W-1:0] max_mem [COLUMNS];
    logic signed [DATA_W-1:0] min_rd_reg, max_rd_reg;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] min_wdata, max_wdata;

    logic [AW+COLUMN_W-1:0]   col_ext;
    logic [AW-1:0]            in_addr, item_addr;
    logic                     in_accept;

    // arithmetic path
    logic signed [DATA_W:0]   num, span, den_full;
    logic [DATA_W-1:0]        an_reg, as_reg, den_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     div_start, div_done;
    logic [PROD_W-1:0]        div_quo;
    logic [MAG_W-1:0]         mag;
    logic signed [SUM_W-1:0]  q_signed, sum;
    logic signed [DATA_W-1:0] sat_result;

    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg;
    logic                     out_load;
    logic signed [DATA_W-1:0] out_scaled;
    logic signed [DATA_W-1:0] res_reg;
    logic                     res_direct_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign col_ext   = {{AW{1'b0}}, in_data.column};
    assign in_addr   = col_ext[AW-1:0];
    assign item_addr = AW'({{AW{1'b0}}, col_reg});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg   <= in_data.func;
            col_reg    <= in_data.column;
            sample_reg <= in_data.sample;
            col_ok_reg <= (32'(in_data.column) < COLUMNS);
        end
    end

    // synchronous stores, read on request accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            min_rd_reg <= min_mem[in_addr];
            max_rd_reg <= max_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            min_mem[mem_waddr] <= min_wdata;
            max_mem[mem_waddr] <= max_wdata;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = item_addr;
        min_wdata = (sample_reg < min_rd_reg) ? sample_reg : min_rd_reg;
        max_wdata = (sample_reg > max_rd_reg) ? sample_reg : max_rd_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            min_wdata = Q_MAX;
            max_wdata = Q_MIN;
        end
        else if (state_reg == S_READ && func_reg == FUNC_GATHER && col_ok_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // operand preparation from the stored extremes
    assign num      = DATA_W'(0) + ({sample_reg[DATA_W-1], sample_reg}
                      - {min_rd_reg[DATA_W-1], min_rd_reg});
    assign span     = {range_high_reg[DATA_W-1], range_high_reg}
                      - {range_low_reg[DATA_W-1], range_low_reg};
    assign den_full = {max_rd_reg[DATA_W-1], max_rd_reg}
                      - {min_rd_reg[DATA_W-1], min_rd_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            an_reg  <= num[DATA_W]  ? DATA_W'(-num)  : num[DATA_W-1:0];
            as_reg  <= span[DATA_W] ? DATA_W'(-span) : span[DATA_W-1:0];
            den_reg <= den_full[DATA_W-1:0];
            neg_reg <= num[DATA_W] != span[DATA_W];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= an_reg * as_reg;
        end
    end

    assign div_start = (state_reg == S_LOAD);

    mmfn_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // quotient far beyond the output range is clamped before the offset add
    assign mag = ((|div_quo[PROD_W-1:MAG_W]) || (div_quo[MAG_W-1:0] > MAG_CLAMP))
                 ? MAG_CLAMP : div_quo[MAG_W-1:0];
    assign q_signed = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign sum      = SUM_W'(range_low_reg) + q_signed;

    always_comb
    begin
        if (sum > SUM_W'(Q_MAX))
            sat_result = Q_MAX;
        else if (sum < SUM_W'(Q_MIN))
            sat_result = Q_MIN;
        else
            sat_result = sum[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
            res_reg <= sat_result;
    end

    // flat, never gathered or out-of-range column answer range_low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_direct_reg <= 1'b0;
        else if (state_reg == S_READ)
            res_direct_reg <= !col_ok_reg || (max_rd_reg <= min_rd_reg);
    end

    assign out_scaled = res_direct_reg ? range_low_reg : res_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        out_load     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_data.func)
                        FUNC_CLEAR:     state_next = S_CLEAR;
                        FUNC_GATHER:    state_next = S_READ;
                        FUNC_NORMALIZE: state_next = S_READ;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (func_reg != FUNC_NORMALIZE)
                    state_next = S_IDLE;
                else if (!col_ok_reg || (max_rd_reg <= min_rd_reg))
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_MUL:  state_next = S_LOAD;
            S_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next   = S_CLEAR;
                clr_cnt_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.scaled      <= out_scaled;
            out_data_reg.column_echo <= col_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
